// ----- design/crmd_pkg.sv -----
package crmd_pkg;

    localparam logic [3:0] HOME_ENTRY_RUNS = 4'd4;
    localparam logic [3:0] HOME_LEAVE_RUNS = 4'd3;
    localparam logic [3:0] BIN_ENTRY_RUNS  = 4'd3;
    localparam logic [3:0] BIN_LEAVE_RUNS  = 4'd2;
    localparam logic [7:0] MIN_RATIO_TOL    = 8'd8;
    localparam logic [7:0] DOM_WINDOW       = 8'd25;
    localparam logic [7:0] FULL_SCALE       = 8'd255;

    localparam int         NUM_JOBS      = 15;
    localparam logic [3:0] JOB_LAST_HOME = 4'd8;
    localparam logic [3:0] JOB_LAST_ALL  = 4'd14;

    localparam logic [2:0] CFG_HOME_COLOR  = 3'd0;
    localparam logic [2:0] CFG_HOME_TOL    = 3'd1;
    localparam logic [2:0] CFG_TARGET_COLOR = 3'd2;
    localparam logic [2:0] CFG_TARGET_TOL  = 3'd3;
    localparam logic [2:0] CFG_TARGET_BIN  = 3'd4;
    localparam logic [2:0] CFG_SENSOR_READY = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [7:0] sample_red;
        logic [7:0] sample_green;
        logic [7:0] sample_blue;
    } t_in;

    typedef struct packed {
        logic       home_present;
        logic       bin_present;
        logic       home_match_now;
        logic       bin_match_now;
        logic [7:0] ratio_red;
        logic [7:0] ratio_green;
        logic [7:0] ratio_blue;
    } t_out;

    typedef struct packed {
        logic       flag;
        logic [3:0] enter_run;
        logic [3:0] exit_run;
    } t_deb;

    function automatic logic [7:0] pick_byte(logic [23:0] p, logic [1:0] k);
        case (k)
            2'd0:    pick_byte = p[23:16];
            2'd1:    pick_byte = p[15:8];
            default: pick_byte = p[7:0];
        endcase
    endfunction

    function automatic logic [9:0] byte_sum(logic [23:0] p);
        byte_sum = {2'b00, p[23:16]} + {2'b00, p[15:8]} + {2'b00, p[7:0]};
    endfunction

    function automatic logic [7:0] absdiff(logic [7:0] a, logic [7:0] b);
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [2:0] dom_mask(logic [23:0] p);
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] mx;
        c0 = p[23:16];
        c1 = p[15:8];
        c2 = p[7:0];
        mx = c0;
        if (c1 > mx) mx = c1;
        if (c2 > mx) mx = c2;
        dom_mask[0] = (absdiff(c0, mx) <= DOM_WINDOW);
        dom_mask[1] = (absdiff(c1, mx) <= DOM_WINDOW);
        dom_mask[2] = (absdiff(c2, mx) <= DOM_WINDOW);
    endfunction

    function automatic logic chan_ok(logic [7:0] ratio, logic [7:0] rref, logic [7:0] qtol);
        logic [7:0] tol;
        tol = (qtol < MIN_RATIO_TOL) ? MIN_RATIO_TOL : qtol;
        chan_ok = (absdiff(ratio, rref) <= tol);
    endfunction

    function automatic t_deb debounce(t_deb d, logic hit, logic [3:0] en_n, logic [3:0] ex_n);
        t_deb r;
        r = d;
        if (hit) begin
            if (r.enter_run < en_n) r.enter_run = r.enter_run + 4'd1;
            r.exit_run = 4'd0;
            if (r.enter_run >= en_n) r.flag = 1'b1;
        end else begin
            r.enter_run = 4'd0;
            if (r.flag) begin
                if (r.exit_run < ex_n) r.exit_run = r.exit_run + 4'd1;
                if (r.exit_run >= ex_n) r.flag = 1'b0;
            end else begin
                r.exit_run = 4'd0;
            end
        end
        debounce = r;
    endfunction

endpackage

// ----- design/color_ratio_match_debouncer_top.sv -----
// Color ratio matcher with debounced home and target-bin presence flags.
// Input channel: i_in_valid with a t_in sample; the block drives o_in_stall and
// takes a transaction when valid is high and stall is low.
// Output channel: o_out_valid with a t_out result; the receiver drives i_out_stall.
// Configuration channel: i_cfg_valid, i_cfg_index and i_cfg_data, with
// o_cfg_ready always high, so every write completes in its cycle.
// Writes to the home registers clear the home debouncer, and writes to the target
// registers clear the bin debouncer; indexes above five are ignored.
// One shared restoring divider produces every ratio and scaled tolerance, one
// quotient bit per cycle. A division loads its operands in the setup state and
// then steps out its eight quotient bits, or ends in the setup state when the
// divisor is zero or the quotient saturates. Nine divisions run without a target
// bin and fifteen with one, then the finish state completes the match and debounce
// and registers the result. With the sensor not ready no division runs and the
// block goes straight from acceptance to the finish state.
// One sample is processed at a time; the next is accepted once the result has
// been moved to the output register, even while that register is stalled.
// A result waiting behind a stalled receiver holds the block in its final cycle.
// Reset restores the register defaults and clears both debouncers.
module color_ratio_match_debouncer_top
    import crmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_state      r_state;
    t_state      n_state;
    logic [23:0] r_home_color;
    logic [23:0] r_home_tol;
    logic [23:0] r_target_color;
    logic [23:0] r_target_tol;
    logic [7:0]  r_target_bin;
    logic        r_sensor_ready;
    logic [23:0] r_sample;
    logic [3:0]  r_job;
    logic [2:0]  r_step;
    logic [15:0] r_rem;
    logic [16:0] r_dsh;
    logic [6:0]  r_qacc;
    logic [7:0]  r_quo [NUM_JOBS];
    t_deb        r_home_deb;
    t_deb        r_bin_deb;
    t_deb        n_home_deb;
    t_deb        n_bin_deb;
    logic        r_out_valid;
    t_out        r_out;
    t_out        n_out;

    logic        in_accept;
    logic        commit;
    logic        cfg_write;
    logic        home_clear;
    logic        bin_clear;
    logic [23:0] src;
    logic [9:0]  den;
    logic [1:0]  lane;
    logic [7:0]  src_byte;
    logic [15:0] num;
    logic        den_zero;
    logic        sat;
    logic [3:0]  job_last;
    logic        job_is_last;
    logic        step_bit;
    logic [9:0]  home_sum;
    logic [9:0]  tgt_sum;
    logic [23:0] ratio_pack;
    logic [2:0]  smask;
    logic        home_now;
    logic        bin_now;

    assign home_sum   = byte_sum(r_home_color);
    assign tgt_sum    = byte_sum(r_target_color);
    assign job_last    = (r_target_bin != 8'd0) ? JOB_LAST_ALL : JOB_LAST_HOME;
    assign job_is_last = (r_job == job_last);
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign home_clear  = cfg_write && (i_cfg_index inside {CFG_HOME_COLOR, CFG_HOME_TOL});
    assign bin_clear   = cfg_write
        && (i_cfg_index inside {CFG_TARGET_COLOR, CFG_TARGET_TOL, CFG_TARGET_BIN});

    always_comb begin
        case (r_job) inside
            [4'd0:4'd2]: begin
                src = r_sample;
                den = byte_sum(r_sample);
            end
            [4'd3:4'd5]: begin
                src = r_home_color;
                den = home_sum;
            end
            [4'd6:4'd8]: begin
                src = r_home_tol;
                den = home_sum;
            end
            [4'd9:4'd11]: begin
                src = r_target_color;
                den = tgt_sum;
            end
            default: begin
                src = r_target_tol;
                den = tgt_sum;
            end
        endcase
        case (r_job) inside
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: lane = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13: lane = 2'd1;
            default: lane = 2'd2;
        endcase
    end

    assign src_byte = pick_byte(src, lane);
    assign num      = {src_byte, 8'd0} - {8'd0, src_byte};
    assign den_zero = (den == 10'd0);
    assign sat      = ({2'b00, num} >= {den, 8'd0});
    assign step_bit = ({1'b0, r_rem} >= r_dsh);

    assign ratio_pack = {r_quo[0], r_quo[1], r_quo[2]};
    assign smask      = dom_mask(ratio_pack);

    always_comb begin
        home_now = (home_sum != 10'd0)
            && ((dom_mask(r_home_color) & smask) != 3'd0)
            && chan_ok(r_quo[0], r_quo[3], r_quo[6])
            && chan_ok(r_quo[1], r_quo[4], r_quo[7])
            && chan_ok(r_quo[2], r_quo[5], r_quo[8]);
        bin_now = (r_target_bin != 8'd0) && (tgt_sum != 10'd0)
            && ((dom_mask(r_target_color) & smask) != 3'd0)
            && chan_ok(r_quo[0], r_quo[9], r_quo[12])
            && chan_ok(r_quo[1], r_quo[10], r_quo[13])
            && chan_ok(r_quo[2], r_quo[11], r_quo[14]);
        if (r_sensor_ready) begin
            n_home_deb = debounce(r_home_deb, home_now, HOME_ENTRY_RUNS, HOME_LEAVE_RUNS);
            n_bin_deb  = debounce(r_bin_deb, bin_now, BIN_ENTRY_RUNS, BIN_LEAVE_RUNS);
            n_out.home_match_now = home_now;
            n_out.bin_match_now  = bin_now;
            if (r_target_bin != 8'd0) begin
                n_out.ratio_red   = r_quo[0];
                n_out.ratio_green = r_quo[1];
                n_out.ratio_blue  = r_quo[2];
            end else begin
                n_out.ratio_red   = 8'd0;
                n_out.ratio_green = 8'd0;
                n_out.ratio_blue  = 8'd0;
            end
        end else begin
            n_home_deb      = r_home_deb;
            n_bin_deb       = r_bin_deb;
            n_home_deb.flag = 1'b0;
            n_bin_deb.flag  = 1'b0;
            n_out.home_match_now = 1'b0;
            n_out.bin_match_now  = 1'b0;
            n_out.ratio_red   = 8'd0;
            n_out.ratio_green = 8'd0;
            n_out.ratio_blue  = 8'd0;
        end
        n_out.home_present = n_home_deb.flag;
        n_out.bin_present  = n_bin_deb.flag;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = r_sensor_ready ? ST_LOAD : ST_FINISH;
                end
            end
            ST_LOAD: begin
                if (den_zero || sat) begin
                    n_state = job_is_last ? ST_FINISH : ST_LOAD;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (r_step == 3'd0) begin
                    n_state = job_is_last ? ST_FINISH : ST_LOAD;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        in_accept   = i_in_valid && (r_state == ST_IDLE);
        commit      = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);
        o_cfg_ready = 1'b1;
        o_out_valid = r_out_valid;
        o_out       = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_in;
            r_job    <= 4'd0;
        end
        case (r_state)
            ST_LOAD: begin
                if (den_zero) begin
                    r_quo[r_job] <= 8'd0;
                    r_job        <= r_job + 4'd1;
                end else if (sat) begin
                    r_quo[r_job] <= FULL_SCALE;
                    r_job        <= r_job + 4'd1;
                end else begin
                    r_rem  <= num;
                    r_dsh  <= {den, 7'd0};
                    r_qacc <= 7'd0;
                    r_step <= 3'd7;
                end
            end
            ST_STEP: begin
                if (step_bit) begin
                    r_rem <= r_rem - r_dsh[15:0];
                end
                r_dsh  <= r_dsh >> 1;
                r_qacc <= {r_qacc[5:0], step_bit};
                r_step <= r_step - 3'd1;
                if (r_step == 3'd0) begin
                    r_quo[r_job] <= {r_qacc, step_bit};
                    r_job        <= r_job + 4'd1;
                end
            end
            default: begin
            end
        endcase
        if (commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_home_deb     <= '0;
            r_bin_deb      <= '0;
            r_home_color   <= 24'h555555;
            r_home_tol     <= 24'h141414;
            r_target_color <= 24'h000000;
            r_target_tol   <= 24'h000000;
            r_target_bin   <= 8'd0;
            r_sensor_ready <= 1'b1;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (home_clear) begin
                r_home_deb <= '0;
            end else if (commit) begin
                r_home_deb <= n_home_deb;
            end
            if (bin_clear) begin
                r_bin_deb <= '0;
            end else if (commit) begin
                r_bin_deb <= n_bin_deb;
            end
            if (cfg_write) begin
                case (i_cfg_index)
                    CFG_HOME_COLOR: begin
                        r_home_color <= i_cfg_data;
                    end
                    CFG_HOME_TOL: begin
                        r_home_tol <= i_cfg_data;
                    end
                    CFG_TARGET_COLOR: begin
                        r_target_color <= i_cfg_data;
                    end
                    CFG_TARGET_TOL: begin
                        r_target_tol <= i_cfg_data;
                    end
                    CFG_TARGET_BIN: begin
                        r_target_bin <= i_cfg_data[7:0];
                    end
                    CFG_SENSOR_READY: begin
                        r_sensor_ready <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // The division sequence never runs past the last tolerance quotient.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD || r_state == ST_STEP) |-> (r_job <= JOB_LAST_ALL))
        else $error("division job index out of range");

    // A home register write leaves the home debouncer cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && (i_cfg_index == CFG_HOME_COLOR || i_cfg_index == CFG_HOME_TOL))
        |=> (r_home_deb == '0))
        else $error("home debouncer not cleared by home register write");

    // The enter runs saturate at their thresholds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_home_deb.enter_run <= HOME_ENTRY_RUNS) && (r_bin_deb.enter_run <= BIN_ENTRY_RUNS))
        else $error("enter run beyond its threshold");

    // The exit runs saturate at their thresholds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_home_deb.exit_run <= HOME_LEAVE_RUNS) && (r_bin_deb.exit_run <= BIN_LEAVE_RUNS))
        else $error("exit run beyond its threshold");

endmodule

// ----- tb/crmd_match_checker.sv -----
module crmd_match_checker
    import crmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic       flag;
        logic [3:0] enter_run;
        logic [3:0] exit_run;
    } t_hyst;

    logic [23:0] home_rgb;
    logic [23:0] home_tol;
    logic [23:0] target_rgb;
    logic [23:0] target_tol;
    logic [7:0]  bin_sel;
    logic        sensor_ok;
    t_hyst       home_hyst;
    t_hyst       bin_hyst;
    t_out        owed_results[$];
    t_out        predicted;
    t_out        oldest;

    function automatic int lane(logic [23:0] p, int k);
        return int'(p[23 - 8 * k -: 8]);
    endfunction

    function automatic int lane_total(logic [23:0] p);
        return lane(p, 0) + lane(p, 1) + lane(p, 2);
    endfunction

    function automatic logic [23:0] chroma_of(logic [23:0] rgb);
        int          total;
        int          k;
        logic [23:0] r;
        total = lane_total(rgb);
        r = '0;
        if (total != 0) begin
            for (k = 0; k < 3; k++) begin
                r[23 - 8 * k -: 8] = 8'((lane(rgb, k) * int'(FULL_SCALE)) / total);
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] dominant_set(logic [23:0] p);
        int         peak;
        int         k;
        logic [2:0] m;
        peak = 0;
        for (k = 0; k < 3; k++) begin
            if (lane(p, k) > peak) peak = lane(p, k);
        end
        for (k = 0; k < 3; k++) begin
            m[k] = ((peak - lane(p, k)) <= int'(DOM_WINDOW));
        end
        return m;
    endfunction

    function automatic logic ref_hit(logic [23:0] ratio, logic [2:0] smask,
                                     logic [23:0] refc, logic [23:0] tolc);
        int          total;
        int          tol;
        int          a;
        int          b;
        int          k;
        logic [23:0] rref;
        logic        hit;
        total = lane_total(refc);
        if (total == 0) return 1'b0;
        if ((dominant_set(refc) & smask) == 3'b000) return 1'b0;
        rref = chroma_of(refc);
        hit = 1'b1;
        for (k = 0; k < 3; k++) begin
            tol = (lane(tolc, k) * int'(FULL_SCALE)) / total;
            if (tol < int'(MIN_RATIO_TOL)) tol = int'(MIN_RATIO_TOL);
            if (tol > int'(FULL_SCALE)) tol = int'(FULL_SCALE);
            a = lane(ratio, k);
            b = lane(rref, k);
            if (((a > b) ? a - b : b - a) > tol) hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic t_hyst hyst_step(t_hyst h, logic hit, logic [3:0] enter_n,
                                        logic [3:0] exit_n);
        t_hyst n;
        n = h;
        if (hit) begin
            n.exit_run = '0;
            if (n.enter_run < enter_n) n.enter_run = n.enter_run + 4'd1;
            n.flag = n.flag | (n.enter_run >= enter_n);
        end else begin
            n.enter_run = '0;
            if (!n.flag) begin
                n.exit_run = '0;
            end else begin
                if (n.exit_run < exit_n) n.exit_run = n.exit_run + 4'd1;
                if (n.exit_run >= exit_n) n.flag = 1'b0;
            end
        end
        return n;
    endfunction

    task automatic judge_sample(input t_in s, output t_out r);
        logic [23:0] ratio;
        logic [2:0]  smask;
        logic        home_now;
        logic        bin_now;
        r = '0;
        if (!sensor_ok) begin
            home_hyst.flag = 1'b0;
            bin_hyst.flag = 1'b0;
        end else begin
            ratio = chroma_of(s);
            smask = dominant_set(ratio);
            home_now = ref_hit(ratio, smask, home_rgb, home_tol);
            bin_now = 1'b0;
            if (bin_sel != 8'd0) begin
                bin_now = ref_hit(ratio, smask, target_rgb, target_tol);
            end else begin
                ratio = '0;
            end
            home_hyst = hyst_step(home_hyst, home_now, HOME_ENTRY_RUNS, HOME_LEAVE_RUNS);
            bin_hyst = hyst_step(bin_hyst, bin_now, BIN_ENTRY_RUNS, BIN_LEAVE_RUNS);
            r.home_present = home_hyst.flag;
            r.bin_present = bin_hyst.flag;
            r.home_match_now = home_now;
            r.bin_match_now = bin_now;
            r.ratio_red = ratio[23:16];
            r.ratio_green = ratio[15:8];
            r.ratio_blue = ratio[7:0];
        end
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [23:0] data);
        case (idx)
            CFG_HOME_COLOR: begin
                home_rgb = data;
                home_hyst = '0;
            end
            CFG_HOME_TOL: begin
                home_tol = data;
                home_hyst = '0;
            end
            CFG_TARGET_COLOR: begin
                target_rgb = data;
                bin_hyst = '0;
            end
            CFG_TARGET_TOL: begin
                target_tol = data;
                bin_hyst = '0;
            end
            CFG_TARGET_BIN: begin
                bin_sel = data[7:0];
                bin_hyst = '0;
            end
            CFG_SENSOR_READY: begin
                sensor_ok = data[0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            home_rgb = 24'h555555;
            home_tol = 24'h141414;
            target_rgb = '0;
            target_tol = '0;
            bin_sel = '0;
            sensor_ok = 1'b1;
            home_hyst = '0;
            bin_hyst = '0;
            owed_results.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) apply_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) begin
                judge_sample(i_in, predicted);
                owed_results.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction arrived with no sample outstanding");
                    o_mismatches++;
                end else begin
                    oldest = owed_results.pop_front();
                    check_field("home_present", oldest.home_present, i_out.home_present);
                    check_field("bin_present", oldest.bin_present, i_out.bin_present);
                    check_field("home_match_now", oldest.home_match_now,
                                i_out.home_match_now);
                    check_field("bin_match_now", oldest.bin_match_now, i_out.bin_match_now);
                    check_field("ratio_red", oldest.ratio_red, i_out.ratio_red);
                    check_field("ratio_green", oldest.ratio_green, i_out.ratio_green);
                    check_field("ratio_blue", oldest.ratio_blue, i_out.ratio_blue);
                end
            end
        end
        o_outstanding = owed_results.size();
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top
    import crmd_pkg::*;
;

    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
    localparam int         LONG_HOLD     = 600;
    localparam int         RANDOM_ITEMS  = 740;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in         i_in        = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out        o_out;
    logic        o_cfg_ready;

    int          mismatches;
    int          outstanding;
    bit          quiet = 1'b0;
    int          hold_ticket = 0;
    int          items_sent = 0;
    logic [23:0] cur_home = 24'h555555;
    logic [23:0] cur_target = 24'h000000;

    always #2 i_clk = ~i_clk;

    color_ratio_match_debouncer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    crmd_match_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    task automatic send_sample(input t_in s);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HOME_COLOR) cur_home = val;
        if (idx == CFG_TARGET_COLOR) cur_target = val;
    endtask

    function automatic t_in near_color(logic [23:0] refc);
        int          peak;
        int          scale;
        int          jitter;
        int          c;
        int          k;
        logic [23:0] p;
        peak = 0;
        for (k = 0; k < 3; k++) begin
            if (int'(refc[23 - 8 * k -: 8]) > peak) peak = int'(refc[23 - 8 * k -: 8]);
        end
        if (peak == 0) begin
            p = 24'($urandom_range(0, 24'hFFFFFF));
        end else begin
            scale = $urandom_range(48, 255);
            for (k = 0; k < 3; k++) begin
                jitter = $urandom_range(0, 4);
                c = (int'(refc[23 - 8 * k -: 8]) * scale) / peak + jitter - 2;
                if (c < 0) c = 0;
                if (c > 255) c = 255;
                p[23 - 8 * k -: 8] = 8'(c);
            end
        end
        return p;
    endfunction

    function automatic logic [23:0] random_color();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    function automatic logic [23:0] random_tolerance();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return {8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
                             8'($urandom_range(0, 40))};
        endcase
    endfunction

    task automatic shuffle_config();
        if ($urandom_range(0, 1) == 1) write_reg(CFG_HOME_COLOR, random_color());
        if ($urandom_range(0, 1) == 1) write_reg(CFG_HOME_TOL, random_tolerance());
        if ($urandom_range(0, 1) == 1) write_reg(CFG_TARGET_COLOR, random_color());
        if ($urandom_range(0, 1) == 1) write_reg(CFG_TARGET_TOL, random_tolerance());
        if ($urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_TARGET_BIN, {16'($urandom_range(0, 16'hFFFF)), 8'h00});
            end else begin
                write_reg(CFG_TARGET_BIN, 24'($urandom_range(0, 24'hFFFFFF)));
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_SENSOR_READY, {23'($urandom_range(0, 23'h7FFFFF)),
                                         1'($urandom_range(0, 5) != 0)});
        end
        if ($urandom_range(0, 7) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                      24'($urandom_range(0, 24'hFFFFFF)));
        end
    endtask

    initial begin
        int hold;
        int holds_granted;
        holds_granted = 0;
        forever begin
            if (hold_ticket > holds_granted) begin
                hold = LONG_HOLD;
                holds_granted++;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 11);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        #2500000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int   phase;
        int   budget;
        int   kind;
        int   run;
        int   i;
        t_in  s;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Home debouncer enters on the fourth gray sample and leaves after three misses.
        repeat (5) send_sample(24'h555555);
        send_sample(24'hFFFFFF);
        send_sample(24'h000000);
        send_sample(24'hFF0000);
        send_sample(24'h00FF00);
        send_sample(24'h0000FF);

        write_reg(CFG_TARGET_COLOR, 24'h20C020);
        write_reg(CFG_TARGET_TOL, 24'h101010);
        write_reg(CFG_TARGET_BIN, 24'h000007);
        repeat (3) send_sample(24'h20C020);
        send_sample(24'h106010);

        // A selected bin with a black target never matches but still reports ratios.
        write_reg(CFG_TARGET_COLOR, 24'h000000);
        send_sample(24'h20C020);
        send_sample(24'h80FF00);

        write_reg(CFG_SENSOR_READY, 24'h000000);
        send_sample(24'h555555);
        send_sample(24'hFFFFFF);
        write_reg(CFG_SENSOR_READY, 24'hFFFFFE);
        write_reg(CFG_SENSOR_READY, 24'h000001);
        send_sample(24'h555555);
        write_reg(CFG_UNUSED_LO, 24'hFFFFFF);
        write_reg(CFG_UNUSED_HI, 24'h000000);
        write_reg(CFG_TARGET_BIN, 24'hAB0000);
        send_sample(24'h555555);

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            shuffle_config();
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 8) begin
                quiet = 1'b1;
                hold_ticket++;
            end
            budget = $urandom_range(16, 32);
            while (budget > 0) begin
                kind = $urandom_range(0, 19);
                run = $urandom_range(1, 8);
                for (i = 0; i < run; i++) begin
                    if (kind < 9) begin
                        s = near_color(cur_home);
                    end else if (kind < 15) begin
                        s = near_color(cur_target);
                    end else begin
                        s = 24'($urandom_range(0, 24'hFFFFFF));
                    end
                    send_sample(s);
                    budget--;
                end
            end
            phase++;
        end

        drain();
        repeat (150) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/crmd_pkg.sv
design/color_ratio_match_debouncer_top.sv
tb/crmd_match_checker.sv
tb/tb_top.sv
